// ----- rtl/efr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    // Escape byte of the serial protocol
    localparam logic [7:0] ESC_BYTE = 8'h2B;

    // Receive phase
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_RECEIVING = 2'd1
    } phase_t;

    // Input command
    typedef enum logic {
        CMD_ARM  = 1'b0,
        CMD_BYTE = 1'b1
    } cmd_t;

    // Result codes
    typedef enum logic [1:0] {
        RC_OK         = 2'd0,
        RC_CHECKSUM   = 2'd1,
        RC_STATUS_BAD = 2'd2
    } result_code_t;

    // One finished frame report
    typedef struct packed {
        result_code_t       code;
        logic [7:0]         status;
        logic signed [31:0] value;
        logic               warning;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/escaped_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte-stuffed reply deframer with checksum.
// Input channel (in_valid/in_ready): cmd 0 arms for a reply of data_bytes
// data bytes; cmd 1 delivers one raw serial byte in rx_byte. Bytes that
// arrive while not armed are dropped. Arming mid-frame restarts reception.
// Output channel (out_valid/out_ready): one report per completed frame with
// result_code, device_status, read_value (little-endian, sign-extended) and
// framing_warning.
// Throughput: one input transfer per cycle while in_ready is high. The deframing
// state updates in the cycle of the transfer; the report is registered, in the
// output register or, while that holds an untaken report, in the skid register.
// A two-entry output stage (output register plus skid register) lets input
// keep flowing while a report waits; in_ready drops only while both
// entries are full, and rises again once out_ready drains one.
// Reset clears the receiver to idle (unarmed) and empties the output stage.
module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 4
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [0:0]         cmd,
    input  wire  [2:0]         data_bytes,
    input  wire  [7:0]         rx_byte,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [1:0]         result_code,
    output logic [7:0]         device_status,
    output logic signed [31:0] read_value,
    output logic               framing_warning
);

    localparam int CNT_W = $clog2(MAX_DATA_BYTES + 4);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_DATA_BYTES);

    // Deframing state
    phase_t           phase_reg,    phase_next;
    logic [CNT_W-1:0] total_reg,    total_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             esc_reg,      esc_next;
    logic [7:0]       sum_reg,      sum_next;
    logic [7:0]       status_reg,   status_next;
    logic [31:0]      data_reg,     data_next;
    logic             warn_reg,     warn_next;
    logic [2:0]       len_reg,      len_next;

    // Output stage
    logic    out_valid_reg,  out_valid_next;
    result_t out_reg,        out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg,       skid_next;

    logic             in_fire;
    logic             emit;
    logic             keep;
    logic [CNT_W-1:0] nd_clamped;
    logic [CNT_W-1:0] lane_pos;
    logic [31:0]      ext_value;
    result_t          res;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // Update deframing state for one transfer
    always_comb
    begin
        phase_next  = phase_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        esc_next    = esc_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        data_next   = data_reg;
        warn_next   = warn_reg;
        len_next    = len_reg;
        keep        = 1'b0;
        emit        = 1'b0;
        lane_pos    = count_reg - CNT_W'(2);

        nd_clamped = (CNT_W'(data_bytes) > MAX_C) ? MAX_C : CNT_W'(data_bytes);

        if (in_fire)
        begin
            if (cmd == CMD_ARM)
            begin
                // Arm: restart reception
                phase_next  = PH_RECEIVING;
                total_next  = nd_clamped + CNT_W'(3);
                count_next  = '0;
                esc_next    = 1'b0;
                sum_next    = '0;
                status_next = '0;
                data_next   = '0;
                warn_next   = 1'b0;
                len_next    = (nd_clamped > CNT_W'(4)) ? 3'd4 : nd_clamped[2:0];
            end
            else if (phase_reg == PH_RECEIVING)
            begin
                // Classify the raw byte
                if (count_reg == '0)
                begin
                    count_next = CNT_W'(1);
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (rx_byte != ESC_BYTE)
                    begin
                        warn_next = 1'b1;
                        keep      = (count_reg < total_reg);
                    end
                end
                else if (count_reg < total_reg)
                begin
                    keep = 1'b1;
                    if (rx_byte == ESC_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                end

                // Store a kept logical byte
                if (keep)
                begin
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        status_next = rx_byte;
                    end
                    else if (count_reg + CNT_W'(1) < total_reg)
                    begin
                        for (int lane = 0; lane < 4; lane++)
                        begin
                            if (lane_pos == CNT_W'(lane))
                            begin
                                data_next[8*lane +: 8] = rx_byte;
                            end
                        end
                    end
                end

                // Close the frame
                if ((count_next >= total_reg) && !esc_next)
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // Sign-extend the data from its width
    always_comb
    begin
        unique case (len_reg)
            3'd0:    ext_value = '0;
            3'd1:    ext_value = {{24{data_next[7]}},  data_next[7:0]};
            3'd2:    ext_value = {{16{data_next[15]}}, data_next[15:0]};
            3'd3:    ext_value = {{8{data_next[23]}},  data_next[23:0]};
            default: ext_value = data_next;
        endcase
    end

    // Build the report
    always_comb
    begin
        priority if (sum_next != 8'h00)
        begin
            res.code = RC_CHECKSUM;
        end
        else if (status_next != 8'h00)
        begin
            res.code = RC_STATUS_BAD;
        end
        else
        begin
            res.code = RC_OK;
        end
        res.status  = status_next;
        res.value   = signed'(ext_value);
        res.warning = warn_next;
    end

    // Route reports through the output and skid registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit;
                out_next       = res;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    // Hold state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            total_reg      <= '0;
            count_reg      <= '0;
            esc_reg        <= 1'b0;
            sum_reg        <= '0;
            status_reg     <= '0;
            data_reg       <= '0;
            warn_reg       <= 1'b0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            esc_reg        <= esc_next;
            sum_reg        <= sum_next;
            status_reg     <= status_next;
            data_reg       <= data_next;
            warn_reg       <= warn_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold report payloads
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_code     = out_reg.code;
    assign device_status   = out_reg.status;
    assign read_value      = out_reg.value;
    assign framing_warning = out_reg.warning;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import efr_pkg::*;

    localparam int MAX_DATA = 4;

    // one input transfer as it goes on the wire
    typedef struct {
        cmd_t       op;
        logic [2:0] nbytes;
        logic [7:0] raw;
    } rx_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [0:0]         cmd = 1'b0;
    logic [2:0]         data_bytes = 3'd0;
    logic [7:0]         rx_byte = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         result_code;
    logic [7:0]         device_status;
    logic signed [31:0] read_value;
    logic               framing_warning;

    escaped_frame_receiver #(.MAX_DATA_BYTES(MAX_DATA)) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .data_bytes      (data_bytes),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_code     (result_code),
        .device_status   (device_status),
        .read_value      (read_value),
        .framing_warning (framing_warning)
    );

    always #10 clk = ~clk;

    rx_item_t pending_items[$];
    rx_item_t cur_item;
    result_t  frame_reports[$];

    int err_cnt = 0;
    int xfer_cnt = 0;
    int report_cnt = 0;
    int warn_cnt = 0;
    int code_cnt[3] = '{0, 0, 0};
    int in_gap = 0;
    int out_gap = 0;

    // mirror of the deframing state
    bit          rx_armed = 1'b0;
    int unsigned frame_len = 0;
    int unsigned kept_cnt = 0;
    int unsigned armed_n = 0;
    bit          esc_wait = 1'b0;
    bit          warn_flag = 1'b0;
    logic [7:0]  sum_acc = 8'd0;
    logic [7:0]  status_acc = 8'd0;
    logic [31:0] data_acc = 32'd0;

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // add one logical byte to the frame being rebuilt
    task automatic keep_logical(input logic [7:0] b);
        int unsigned pos;
        pos = kept_cnt;
        if (pos >= 1) begin
            sum_acc = sum_acc + b;
            if (pos == 1)
                status_acc = b;
            else if (pos + 1 < frame_len && pos - 2 < 4)
                data_acc[8*(pos-2) +: 8] = b;
        end
        kept_cnt = pos + 1;
    endtask

    // advance the deframer mirror by one transfer, queue the report it causes
    task automatic deframe_step(input rx_item_t it);
        result_t rep;
        if (it.op == CMD_ARM) begin
            armed_n    = (it.nbytes > MAX_DATA) ? MAX_DATA : it.nbytes;
            frame_len  = armed_n + 3;
            kept_cnt   = 0;
            esc_wait   = 1'b0;
            sum_acc    = 8'd0;
            status_acc = 8'd0;
            data_acc   = 32'd0;
            warn_flag  = 1'b0;
            rx_armed   = 1'b1;
            return;
        end
        // drop bytes while unarmed
        if (!rx_armed)
            return;
        if (kept_cnt == 0) begin
            kept_cnt = 1;
        end else if (esc_wait) begin
            esc_wait = 1'b0;
            if (it.raw != ESC_BYTE) begin
                warn_flag = 1'b1;
                if (kept_cnt < frame_len)
                    keep_logical(it.raw);
            end
        end else if (kept_cnt < frame_len) begin
            keep_logical(it.raw);
            if (it.raw == ESC_BYTE)
                esc_wait = 1'b1;
        end
        if (kept_cnt < frame_len || esc_wait)
            return;
        if (sum_acc != 8'd0)
            rep.code = RC_CHECKSUM;
        else if (status_acc != 8'd0)
            rep.code = RC_STATUS_BAD;
        else
            rep.code = RC_OK;
        rep.status = status_acc;
        case (armed_n)
            0:       rep.value = 32'sd0;
            1:       rep.value = {{24{data_acc[7]}}, data_acc[7:0]};
            2:       rep.value = {{16{data_acc[15]}}, data_acc[15:0]};
            3:       rep.value = {{8{data_acc[23]}}, data_acc[23:0]};
            default: rep.value = data_acc;
        endcase
        rep.warning = warn_flag;
        frame_reports.push_back(rep);
        rx_armed = 1'b0;
    endtask

    // input driver: hold each transfer until accepted, idle in short bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                deframe_step(cur_item);
                xfer_cnt++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 200 && (xfer_cnt / 150) % 4 != 3
                             && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= cur_item.op;
                    data_bytes <= cur_item.nbytes;
                    rx_byte    <= cur_item.raw;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // compare one accepted report with the oldest expected one
    task automatic check_report();
        result_t want;
        if (frame_reports.size() == 0) begin
            log_mismatch("report with none pending, value", read_value, 32'd0);
            return;
        end
        want = frame_reports.pop_front();
        report_cnt++;
        if (want.code <= RC_STATUS_BAD)
            code_cnt[want.code]++;
        if (want.warning)
            warn_cnt++;
        if (result_code !== want.code)
            log_mismatch("result_code", result_code, want.code);
        if (device_status !== want.status)
            log_mismatch("device_status", device_status, want.status);
        if (read_value !== want.value)
            log_mismatch("read_value", read_value, want.value);
        if (framing_warning !== want.warning)
            log_mismatch("framing_warning", framing_warning, want.warning);
    endtask

    // output monitor: check each transfer, stall in short bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                check_report();
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (pending_items.size() > 200 && (report_cnt / 20) % 4 != 3
                         && $urandom_range(0, 3) == 0) begin
                out_gap = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input cmd_t op, input logic [2:0] nb, input logic [7:0] rb);
        rx_item_t it;
        it.op     = op;
        it.nbytes = nb;
        it.raw    = rb;
        pending_items.push_back(it);
    endtask

    task automatic push_arm(input logic [2:0] nb);
        push_item(CMD_ARM, nb, 8'($urandom));
    endtask

    task automatic push_raw(input logic [7:0] rb);
        push_item(CMD_BYTE, 3'($urandom), rb);
    endtask

    // build one reply: mostly well formed, sometimes broken or cut short
    task automatic queue_random_frame();
        logic [2:0] nd;
        int         eff;
        int         pick;
        int         cut;
        logic [7:0] logical[$];
        logic [7:0] raw_seq[$];
        logic [7:0] chk;
        logic [7:0] filler;
        pick = $urandom_range(0, 19);
        if (pick < 5)
            nd = 3'd0;
        else if (pick < 10)
            nd = 3'd2;
        else if (pick < 15)
            nd = 3'd4;
        else
            nd = 3'($urandom_range(0, 7));
        eff = (nd > MAX_DATA) ? MAX_DATA : nd;
        push_arm(nd);
        // start byte takes any value, the escape byte too
        raw_seq.push_back(($urandom_range(0, 5) == 0) ? ESC_BYTE : 8'($urandom));
        logical.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00);
        for (int i = 0; i < eff; i++)
            logical.push_back(($urandom_range(0, 4) == 0) ? ESC_BYTE : 8'($urandom));
        chk = 8'd0;
        foreach (logical[i])
            chk = chk - logical[i];
        // steer the checksum onto the escape byte now and then
        if ($urandom_range(0, 7) == 0) begin
            logical[logical.size()-1] = logical[logical.size()-1] + chk - ESC_BYTE;
            chk = ESC_BYTE;
        end
        if ($urandom_range(0, 9) == 0)
            chk = chk + 8'($urandom_range(1, 255));
        logical.push_back(chk);
        // stuff escapes, leaving a lone one now and then
        foreach (logical[i]) begin
            raw_seq.push_back(logical[i]);
            if (logical[i] == ESC_BYTE) begin
                if ($urandom_range(0, 5) != 0) begin
                    raw_seq.push_back(ESC_BYTE);
                end else if (i == logical.size() - 1) begin
                    filler = 8'($urandom_range(0, 254));
                    if (filler >= ESC_BYTE)
                        filler++;
                    raw_seq.push_back(filler);
                end
            end
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, raw_seq.size() - 1)
                                           : raw_seq.size();
        for (int i = 0; i < cut; i++)
            push_raw(raw_seq[i]);
        // stray bytes after the frame
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) push_raw(8'($urandom));
    endtask

    initial begin
        // byte while unarmed
        push_raw(8'hFF);
        // no data, start byte equal to the escape byte
        push_arm(3'd0);
        push_raw(ESC_BYTE); push_raw(8'h00); push_raw(8'h00);
        // oversized length, doubled escape in the data, negative full-width value
        push_arm(3'd7);
        push_raw(8'h55); push_raw(8'h00);
        push_raw(ESC_BYTE); push_raw(ESC_BYTE); push_raw(8'h00); push_raw(8'h80);
        push_raw(8'hFF); push_raw(8'h56);
        // bad status, lone escape in the data, escaped checksum with a dropped byte
        push_arm(3'd2);
        push_raw(8'h00); push_raw(8'hA9); push_raw(ESC_BYTE); push_raw(8'h01);
        push_raw(ESC_BYTE); push_raw(8'h00);
        // rearm while busy, then a one-byte negative value with a bad checksum
        push_arm(3'd3);
        push_arm(3'd1);
        push_raw(8'h7E); push_raw(8'h00); push_raw(8'h80); push_raw(8'h00);

        while (pending_items.size() < 1300)
            queue_random_frame();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // drain input, then outstanding reports, then let the pipe settle
        @(negedge clk);
        while (pending_items.size() > 0 || in_valid)
            @(negedge clk);
        while (frame_reports.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d transfers; checked %0d frame reports", xfer_cnt, report_cnt);
        $display("Reports: %0d ok, %0d checksum errors, %0d bad status, %0d with warning",
                 code_cnt[0], code_cnt[1], code_cnt[2], warn_cnt);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Timeout with %0d reports outstanding", frame_reports.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
